@@ rtl/core/activity_burst_statistics_core_macros.svh @@
// assertion macros for the activity burst statistics core
`ifndef ACTIVITY_BURST_STATISTICS_CORE_MACROS_SVH
`define ACTIVITY_BURST_STATISTICS_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define ABS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abs assertion failed");

// next-cycle implication, disabled in reset
`define ABS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abs assertion failed");

`endif

@@ rtl/core/abs_pkg.sv @@
package abs_pkg;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STOP  = 1'b1;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BUSY = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;

  typedef struct packed {
    logic        func;
    logic [31:0] event_time;
  } abs_in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] interval_begin;
    logic [31:0] interval_length;
    logic        out_of_order;
    logic [31:0] longest_busy;
    logic [31:0] longest_busy_at;
    logic [31:0] shortest_busy;
    logic [31:0] shortest_busy_at;
    logic [31:0] longest_idle;
    logic [31:0] longest_idle_at;
    logic [31:0] shortest_idle;
    logic [31:0] shortest_idle_at;
  } abs_out_t;

  typedef struct packed {
    logic [31:0] longest;
    logic [31:0] longest_at;
    logic [31:0] shortest;
    logic [31:0] shortest_at;
  } abs_ext_t;

  typedef struct packed {
    logic        is_busy;
    logic        stopped_once;
    logic        busy_valid;
    logic        idle_valid;
    logic [31:0] last_start;
    logic [31:0] last_stop;
    abs_ext_t    busy_ext;
    abs_ext_t    idle_ext;
  } abs_state_t;

  // first interval seeds both extremes, ties keep the earlier one
  function automatic abs_ext_t abs_fold(abs_ext_t ext, logic valid,
                                        logic [31:0] len, logic [31:0] start_t);
    abs_ext_t res;
    res = ext;
    if (!valid) begin
      res.longest     = len;
      res.longest_at  = start_t;
      res.shortest    = len;
      res.shortest_at = start_t;
    end else begin
      if (len > ext.longest) begin
        res.longest    = len;
        res.longest_at = start_t;
      end
      if (len < ext.shortest) begin
        res.shortest    = len;
        res.shortest_at = start_t;
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/activity_burst_statistics_core.sv @@
// activity burst statistics core
// input channel: in_valid / in_stall / in_data carry one start or stop event
// (func, event_time). output channel: out_valid / out_stall / out_data carry
// exactly one result item per event: the interval it completed (if any), an
// out-of-order flag and the busy and idle extremes after that event.
// an item is taken on a rising edge with valid high and stall low.
// order: an accepted event is held in the input register, is folded into the
// statistics state and lands in the output register once the output register
// is not holding a stalled result.
// throughput: one event per cycle if unstalled; the state update is a single
// subtract and two compares per interval kind between the input and output
// registers. when the receiver stalls, the output register holds its
// result, the input register fills and then in_stall rises; nothing is lost
// or repeated. reset (rst_n low, synchronous) empties both registers and
// clears the state: idle, no stop seen, all statistics zero.
module activity_burst_statistics_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  abs_pkg::abs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output abs_pkg::abs_out_t out_data
);

  abs_pkg::abs_in_t    in_r;
  logic                in_vld_r;
  abs_pkg::abs_out_t   out_r;
  logic                out_vld_r;
  abs_pkg::abs_state_t state_r;
  abs_pkg::abs_state_t state_nxt;
  abs_pkg::abs_out_t   result_nxt;
  logic                out_hold;
  logic                adv;

  assign out_hold = out_vld_r && out_stall;
  assign adv      = in_vld_r && !out_hold;
  assign in_stall = in_vld_r && out_hold;

  abs_update u_update (
    .state      (state_r),
    .item       (in_r),
    .state_nxt  (state_nxt),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (!out_hold) begin
        out_vld_r <= in_vld_r;
      end
      if (adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/abs_update.sv @@
module abs_update (
  input  abs_pkg::abs_state_t state,
  input  abs_pkg::abs_in_t    item,
  output abs_pkg::abs_state_t state_nxt,
  output abs_pkg::abs_out_t   result_nxt
);

  logic [31:0] busy_len;
  logic [31:0] idle_len;
  logic [1:0]  kind;
  logic [31:0] ival_begin;
  logic [31:0] ival_len;
  logic        ooo;

  assign busy_len = item.event_time - state.last_start;
  assign idle_len = item.event_time - state.last_stop;

  always_comb begin
    state_nxt  = state;
    kind       = abs_pkg::KIND_NONE;
    ival_begin = '0;
    ival_len   = '0;
    ooo        = 1'b0;
    unique case (item.func)
      abs_pkg::FUNC_START: begin
        if (state.is_busy) begin
          ooo = 1'b1;
        end else begin
          if (state.stopped_once) begin
            kind                 = abs_pkg::KIND_IDLE;
            ival_begin           = state.last_stop;
            ival_len             = idle_len;
            state_nxt.idle_ext   = abs_pkg::abs_fold(state.idle_ext, state.idle_valid,
                                                     idle_len, state.last_stop);
            state_nxt.idle_valid = 1'b1;
          end
          state_nxt.last_start = item.event_time;
          state_nxt.is_busy    = 1'b1;
        end
      end
      abs_pkg::FUNC_STOP: begin
        if (!state.is_busy) begin
          ooo = 1'b1;
        end else begin
          kind                   = abs_pkg::KIND_BUSY;
          ival_begin             = state.last_start;
          ival_len               = busy_len;
          state_nxt.busy_ext     = abs_pkg::abs_fold(state.busy_ext, state.busy_valid,
                                                     busy_len, state.last_start);
          state_nxt.busy_valid   = 1'b1;
          state_nxt.stopped_once = 1'b1;
          state_nxt.last_stop    = item.event_time;
          state_nxt.is_busy      = 1'b0;
        end
      end
      default: begin
        ooo = 1'b0;
      end
    endcase
  end

  always_comb begin
    result_nxt.record_kind      = kind;
    result_nxt.interval_begin   = ival_begin;
    result_nxt.interval_length  = ival_len;
    result_nxt.out_of_order     = ooo;
    result_nxt.longest_busy     = state_nxt.busy_ext.longest;
    result_nxt.longest_busy_at  = state_nxt.busy_ext.longest_at;
    result_nxt.shortest_busy    = state_nxt.busy_ext.shortest;
    result_nxt.shortest_busy_at = state_nxt.busy_ext.shortest_at;
    result_nxt.longest_idle     = state_nxt.idle_ext.longest;
    result_nxt.longest_idle_at  = state_nxt.idle_ext.longest_at;
    result_nxt.shortest_idle    = state_nxt.idle_ext.shortest;
    result_nxt.shortest_idle_at = state_nxt.idle_ext.shortest_at;
  end

endmodule

@@ rtl/core/abs_checker.sv @@
`include "activity_burst_statistics_core_macros.svh"

module abs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input abs_pkg::abs_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input abs_pkg::abs_out_t out_data
);

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^in_data);

  `ABS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  `ABS_ASSERT_NOW(a_ooo_no_record, clk, rst_n, out_valid && out_data.out_of_order, out_data.record_kind == abs_pkg::KIND_NONE)

  `ABS_ASSERT_NOW(a_none_zero, clk, rst_n, out_valid && out_data.record_kind == abs_pkg::KIND_NONE, out_data.interval_begin == 32'd0 && out_data.interval_length == 32'd0)

  `ABS_ASSERT_NOW(a_busy_order, clk, rst_n, out_valid && out_data.record_kind == abs_pkg::KIND_BUSY, out_data.longest_busy >= out_data.shortest_busy && out_data.longest_busy >= out_data.interval_length)

endmodule

bind activity_burst_statistics_core abs_checker u_abs_checker (.*);
